@@ hw/rtl/d2v_pkg.sv @@
// Shared constants, widths and stage types for the 2D distance and variance pipeline.
package d2v_pkg;

  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 8;

  localparam int DIST_W = 29;
  localparam int VAR_W  = 44;
  localparam int VIN_W  = 32;

  localparam int MW   = COORD_BITS + 1;
  localparam int SQW  = 2 * MW;
  localparam int D2W  = SQW + 1;
  localparam int VW   = VIN_W + 1;
  localparam int LO   = (VW + 1) / 2;
  localparam int PW   = SQW + VW;
  localparam int NW   = PW + 3;
  localparam int DNW  = NW + FRAC_BITS;
  localparam int RMW  = D2W + 1;
  localparam int SVW  = 2 * ((D2W + 2 * FRAC_BITS + 1) / 2);
  localparam int RTW  = SVW / 2;
  localparam int SRW  = RTW + 3;

  localparam int DIV_STEPS = DNW;
  localparam int SQ_STEPS  = RTW;
  localparam int FRONT     = 6;
  localparam int LAT       = FRONT + DIV_STEPS;

  localparam logic [VAR_W-1:0] VAR_POS_LIM = {1'b0, {(VAR_W-1){1'b1}}};
  localparam logic [VAR_W-1:0] VAR_NEG_LIM = {1'b1, {(VAR_W-1){1'b0}}};
  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

  typedef struct packed {
    logic             coin;
    logic             neg;
    logic [D2W-1:0]   d2;
    logic [RMW-1:0]   rem;
    logic [DNW-1:0]   num;
    logic [VAR_W-1:0] q;
    logic             over;
    logic [SRW-1:0]   srem;
    logic [SVW-1:0]   sv;
    logic [RTW-1:0]   root;
  } dstg_t;

  function automatic dstg_t stage_step(dstg_t s, logic do_sqrt);
    dstg_t          r;
    logic [RMW-1:0] rm;
    logic [SRW-1:0] sr;
    logic [SRW-1:0] tr;
    r    = s;
    rm   = {s.rem[RMW-2:0], s.num[DNW-1]};
    r.num  = {s.num[DNW-2:0], 1'b0};
    r.over = s.over | s.q[VAR_W-1];
    if (rm >= RMW'(s.d2)) begin
      r.rem = rm - RMW'(s.d2);
      r.q   = {s.q[VAR_W-2:0], 1'b1};
    end else begin
      r.rem = rm;
      r.q   = {s.q[VAR_W-2:0], 1'b0};
    end
    if (do_sqrt) begin
      sr   = {s.srem[SRW-3:0], s.sv[SVW-1:SVW-2]};
      tr   = SRW'({s.root, 2'b01});
      r.sv = {s.sv[SVW-3:0], 2'b00};
      if (sr >= tr) begin
        r.srem = sr - tr;
        r.root = {s.root[RTW-2:0], 1'b1};
      end else begin
        r.srem = sr;
        r.root = {s.root[RTW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/distance_2d_with_variance.sv @@
// Top level: pipelined 2D distance with first-order propagated variance.
// Fully pipelined: one point pair enters per cycle, and each result passes
// through six front stages for differences, products and the signed
// numerator, then one stage per bit of the 86-bit restoring divider, with
// the 30 steps of the square root riding in the first stages. A stall on
// the output holds the whole pipeline. Coincident points give a flag and
// zero outputs.
module distance_2d_with_variance import d2v_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic        [VIN_W-1:0]      a_var_x_i,
  input  logic signed [VIN_W-1:0]      a_cov_xy_i,
  input  logic        [VIN_W-1:0]      a_var_y_i,
  input  logic        [VIN_W-1:0]      b_var_x_i,
  input  logic signed [VIN_W-1:0]      b_cov_xy_i,
  input  logic        [VIN_W-1:0]      b_var_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic        [DIST_W-1:0]     distance_o,
  output logic signed [VAR_W-1:0]      distance_variance_o,
  output logic                         coincident_o
);

  logic           en;
  logic [LAT-1:0] vld_q;

  logic [MW-1:0]  dxw, dyw;
  logic [VW-1:0]  scw;
  logic [MW-1:0]  mx_q, my_q;
  logic [VW-1:0]  sa_q, sb_q, scm_q, sa2_q, sb2_q, scm2_q;
  logic           cneg_q, cneg2_q, cneg3_q, cneg4_q;
  logic [SQW-1:0] dx2_q, dy2_q, mxy_q;
  logic [D2W-1:0] d2_q, d2b_q, d2c_q;
  logic [PW-1:0]  pxl_q, pxh_q, pyl_q, pyh_q, pcl_q, pch_q;
  logic [NW-1:0]  t_q, c_q;
  logic [NW:0]    snum_q;
  logic           coin_q, coin2_q;
  dstg_t          st_q [DIV_STEPS+1];
  dstg_t          st0_d;
  dstg_t          lst;
  logic [VAR_W-1:0] lim, qm, vout;

  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign dxw = {bx_i[COORD_BITS-1], bx_i} - {ax_i[COORD_BITS-1], ax_i};
  assign dyw = {by_i[COORD_BITS-1], by_i} - {ay_i[COORD_BITS-1], ay_i};
  assign scw = {a_cov_xy_i[VIN_W-1], a_cov_xy_i} + {b_cov_xy_i[VIN_W-1], b_cov_xy_i};

  always_comb begin
    st0_d      = '0;
    st0_d.coin = coin2_q;
    st0_d.neg  = snum_q[NW];
    st0_d.d2   = d2c_q;
    st0_d.num  = {(snum_q[NW] ? NW'(-snum_q) : snum_q[NW-1:0]), {FRAC_BITS{1'b0}}};
    st0_d.sv   = SVW'({d2c_q, {(2*FRAC_BITS){1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q    <= dxw[MW-1] ? -dxw : dxw;
      my_q    <= dyw[MW-1] ? -dyw : dyw;
      cneg_q  <= dxw[MW-1] ^ dyw[MW-1];
      sa_q    <= {1'b0, a_var_x_i} + {1'b0, b_var_x_i};
      sb_q    <= {1'b0, a_var_y_i} + {1'b0, b_var_y_i};
      scm_q   <= scw[VW-1] ? -scw : scw;

      dx2_q   <= SQW'(mx_q) * SQW'(mx_q);
      dy2_q   <= SQW'(my_q) * SQW'(my_q);
      mxy_q   <= SQW'(mx_q) * SQW'(my_q);
      sa2_q   <= sa_q;
      sb2_q   <= sb_q;
      scm2_q  <= scm_q;
      cneg2_q <= cneg_q;

      d2_q    <= D2W'(dx2_q) + D2W'(dy2_q);
      pxl_q   <= PW'(dx2_q) * PW'(sa2_q[LO-1:0]);
      pxh_q   <= PW'(dx2_q) * PW'(sa2_q[VW-1:LO]);
      pyl_q   <= PW'(dy2_q) * PW'(sb2_q[LO-1:0]);
      pyh_q   <= PW'(dy2_q) * PW'(sb2_q[VW-1:LO]);
      pcl_q   <= PW'(mxy_q) * PW'(scm2_q[LO-1:0]);
      pch_q   <= PW'(mxy_q) * PW'(scm2_q[VW-1:LO]);
      cneg3_q <= cneg2_q;

      t_q     <= NW'(pxl_q) + (NW'(pxh_q) << LO) + NW'(pyl_q) + (NW'(pyh_q) << LO);
      c_q     <= (NW'(pcl_q) + (NW'(pch_q) << LO)) << 1;
      cneg4_q <= cneg3_q;
      d2b_q   <= d2_q;
      coin_q  <= (d2_q == '0);

      snum_q  <= cneg4_q ? ({1'b0, t_q} - {1'b0, c_q}) : ({1'b0, t_q} + {1'b0, c_q});
      d2c_q   <= d2b_q;
      coin2_q <= coin_q;
    end
  end

  for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          st_q[k] <= st0_d;
        end
      end
    end else begin : g_step
      always_ff @(posedge clk_i) begin
        if (en) begin
          st_q[k] <= stage_step(st_q[k-1], (k <= SQ_STEPS));
        end
      end
    end
  end

  assign lst  = st_q[DIV_STEPS];
  assign lim  = lst.neg ? VAR_NEG_LIM : VAR_POS_LIM;
  assign qm   = (lst.over || (lst.q > lim)) ? lim : lst.q;
  assign vout = lst.neg ? -qm : qm;

  assign coincident_o        = lst.coin;
  assign distance_variance_o = lst.coin ? '0 : vout;
  assign distance_o          = lst.coin ? '0 :
                               ((RTW'(DIST_MAX) < lst.root) ? DIST_MAX : DIST_W'(lst.root));

endmodule

@@ hw/rtl/d2v_checker.sv @@
// Port-level checker for the distance pipeline, bound to the top level.
module d2v_checker import d2v_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [DIST_W-1:0]        distance_o,
  input logic signed [VAR_W-1:0]  distance_variance_o,
  input logic                     coincident_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_coin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coincident_o |-> distance_o == '0 && distance_variance_o == '0)
    else $error("coincident transaction with nonzero outputs");

  a_dist_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !coincident_o |-> distance_o != '0)
    else $error("distinct points gave zero distance");

endmodule

bind distance_2d_with_variance d2v_checker u_d2v_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .distance_o          (distance_o),
  .distance_variance_o (distance_variance_o),
  .coincident_o        (coincident_o)
);
